@@ hdl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stable matching engine
// Beat payload structs, function codes, sequencer states and id widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

  // Fixed field widths
  localparam int ID_W           = 5;
  localparam int CNT_W          = 6;
  localparam int FUNC_W         = 2;
  localparam int ID_LIMIT       = 32;
  localparam int MAX_PEOPLE_DEF = 32;

  localparam logic [ID_W-1:0]  UNMATCHED_ID = 5'h1F;
  localparam logic [CNT_W-1:0] SIZE_RESET   = 6'd32;

  // Input function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_PROP = 2'd0,
    FUNC_LOAD_ACC  = 2'd1,
    FUNC_START     = 2'd2
  } sme_func_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROPOSE,
    ST_PREF,
    ST_RANK_NEW,
    ST_RANK_HOLD,
    ST_EMIT
  } sme_state_e;

  // Input beat
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   person;
    logic [ID_W-1:0]   rank;
    logic [ID_W-1:0]   partner;
  } sme_in_t;

  // Output beat
  typedef struct packed {
    logic [ID_W-1:0] proposer_id;
    logic [ID_W-1:0] matched_acceptor;
    logic            last;
  } sme_out_t;

endpackage

`default_nettype wire

@@ hdl/sme_ram.sv @@
// ----------------------------------------------------------------------------
// sme_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/stable_matching_engine_unit.sv @@
// ----------------------------------------------------------------------------
// stable_matching_engine_unit: proposer-optimal Gale-Shapley matcher
// Preference lists live in one RAM, acceptor ranks (inverted lists) in another.
// A start beat runs the proposal loop from a FIFO of free proposers, then
// streams one pair per proposer in index order.
// ----------------------------------------------------------------------------
// Load beats: accepted one per cycle while idle, no result.
// Start beat: each proposal reads the preference RAM, and also reads the rank RAM twice
//   when the acceptor is taken; an exhausted proposer is popped without a proposal. At
//   most n*n proposals, then n pairs at one a cycle when not stalled.
// Input is stalled from the start beat until the last pair is in the output reg.
// Reset: async active low; control state clears, size_q returns to 32; RAMs keep data.
`default_nettype none

module stable_matching_engine_unit
  import sme_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sme_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sme_out_t              out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int DEPTH   = MAX_PEOPLE * MAX_PEOPLE;
  localparam int AW      = $clog2(DEPTH);
  localparam int LIM     = (MAX_PEOPLE < ID_LIMIT) ? MAX_PEOPLE : ID_LIMIT;
  localparam logic [AW-1:0]    MAXP = AW'(MAX_PEOPLE);
  localparam logic [CNT_W-1:0] LIMN = CNT_W'(LIM);

  sme_state_e state_q, state_d;

  logic [CNT_W-1:0] size_q;
  logic [CNT_W-1:0] n_w;

  logic [ID_W-1:0]  fifo_q [ID_LIMIT];
  logic [ID_W-1:0]  head_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ID_LIMIT-1:0] taken_q;
  logic [ID_LIMIT-1:0] matched_q;
  logic [CNT_W-1:0] nc_q [ID_LIMIT];
  logic [ID_W-1:0]  holder_q [ID_LIMIT];
  logic [ID_W-1:0]  engaged_q [ID_LIMIT];

  logic [ID_W-1:0] m_q, w_q, h_q, r_q;
  logic [ID_W-1:0] emit_idx_q;
  logic            out_valid_q;
  sme_out_t        out_q;

  logic            in_fire, load_ok, start;
  logic            pref_we, rank_we;
  logic [AW-1:0]   pref_waddr, rank_waddr, pref_raddr, rank_raddr;
  logic [ID_W-1:0] pref_rdata, rank_rdata;
  logic [ID_W-1:0] head_m;
  logic [CNT_W-1:0] head_nc;
  logic            do_pop, do_adv, do_accept, do_displace, emit_load, emit_last;

  // Active size, clamped to 1..LIM
  always_comb begin
    priority if (size_q == '0) begin
      n_w = CNT_W'(1);
    end else if (size_q > LIMN) begin
      n_w = LIMN;
    end else begin
      n_w = size_q;
    end
  end

  // Input handshake and load decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign load_ok    = (32'(in_data_i.person) < MAX_PEOPLE) &&
                      (32'(in_data_i.rank) < MAX_PEOPLE) &&
                      (32'(in_data_i.partner) < MAX_PEOPLE);
  assign pref_we    = in_fire && load_ok && (in_data_i.func == FUNC_LOAD_PROP);
  assign rank_we    = in_fire && load_ok && (in_data_i.func == FUNC_LOAD_ACC);
  assign start      = in_fire && (in_data_i.func == FUNC_START);

  assign pref_waddr = AW'(in_data_i.person) * MAXP + AW'(in_data_i.rank);
  assign rank_waddr = AW'(in_data_i.person) * MAXP + AW'(in_data_i.partner);

  // Head of the free FIFO and its next choice
  assign head_m  = fifo_q[head_q];
  assign head_nc = nc_q[head_m];

  // RAM read addresses
  assign pref_raddr = AW'(head_m) * MAXP + AW'(head_nc);
  always_comb begin
    if (state_q == ST_PREF) begin
      rank_raddr = AW'(pref_rdata) * MAXP + AW'(m_q);
    end else begin
      rank_raddr = AW'(w_q) * MAXP + AW'(h_q);
    end
  end

  sme_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_pref_ram (
    .clk_i   (clk_i),
    .we_i    (pref_we),
    .waddr_i (pref_waddr),
    .wdata_i (in_data_i.partner),
    .raddr_i (pref_raddr),
    .rdata_o (pref_rdata)
  );

  sme_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (in_data_i.rank),
    .raddr_i (rank_raddr),
    .rdata_o (rank_rdata)
  );

  assign emit_last = ({1'b0, emit_idx_q} == (n_w - CNT_W'(1)));

  // Sequencer: next state and step controls
  always_comb begin
    state_d     = state_q;
    do_pop      = 1'b0;
    do_adv      = 1'b0;
    do_accept   = 1'b0;
    do_displace = 1'b0;
    emit_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_PROPOSE;
        end
      end
      ST_PROPOSE: begin
        priority if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else if (({1'b0, head_m} >= n_w) || (head_nc >= n_w)) begin
          do_pop = 1'b1;
        end else begin
          do_adv  = 1'b1;
          state_d = ST_PREF;
        end
      end
      ST_PREF: begin
        priority if ({1'b0, pref_rdata} >= n_w) begin
          state_d = ST_PROPOSE;
        end else if (!taken_q[pref_rdata]) begin
          do_accept = 1'b1;
          do_pop    = 1'b1;
          state_d   = ST_PROPOSE;
        end else begin
          state_d = ST_RANK_NEW;
        end
      end
      ST_RANK_NEW: begin
        state_d = ST_RANK_HOLD;
      end
      ST_RANK_HOLD: begin
        // equal ranks: the newcomer wins
        if (r_q <= rank_rdata) begin
          do_displace = 1'b1;
        end
        state_d = ST_PROPOSE;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit_load = 1'b1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SIZE_RESET;
      head_q      <= '0;
      cnt_q       <= '0;
      taken_q     <= '0;
      matched_q   <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ID_LIMIT; i++) begin
        nc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end

      // run setup
      if (start) begin
        head_q     <= '0;
        cnt_q      <= n_w;
        taken_q    <= '0;
        matched_q  <= '0;
        emit_idx_q <= '0;
        for (int i = 0; i < ID_LIMIT; i++) begin
          nc_q[i] <= '0;
        end
      end

      // proposal pointer
      if (do_adv) begin
        nc_q[head_m] <= head_nc + CNT_W'(1);
      end

      // FIFO bookkeeping; a displace pops and pushes, count unchanged
      if (do_pop) begin
        head_q <= head_q + ID_W'(1);
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      if (do_displace) begin
        head_q <= head_q + ID_W'(1);
      end

      if (do_accept) begin
        taken_q[pref_rdata] <= 1'b1;
        matched_q[m_q]      <= 1'b1;
      end
      // holder drops out, newcomer takes its place
      if (do_displace) begin
        matched_q <= (matched_q & ~(ID_LIMIT'(1) << h_q)) | (ID_LIMIT'(1) << m_q);
      end

      // output register
      if (emit_load) begin
        out_valid_q <= 1'b1;
        emit_idx_q  <= emit_idx_q + ID_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int i = 0; i < ID_LIMIT; i++) begin
        fifo_q[i] <= ID_W'(i);
      end
    end
    if (do_displace) begin
      fifo_q[head_q + cnt_q[ID_W-1:0]] <= h_q;
      holder_q[w_q]  <= m_q;
      engaged_q[m_q] <= w_q;
    end
    if (do_accept) begin
      holder_q[pref_rdata] <= m_q;
      engaged_q[m_q]       <= pref_rdata;
    end
    if (do_adv) begin
      m_q <= head_m;
    end
    if (state_q == ST_PREF) begin
      w_q <= pref_rdata;
      h_q <= holder_q[pref_rdata];
    end
    if (state_q == ST_RANK_NEW) begin
      r_q <= rank_rdata;
    end
    if (emit_load) begin
      out_q.proposer_id      <= emit_idx_q;
      out_q.matched_acceptor <= matched_q[emit_idx_q] ? engaged_q[emit_idx_q] : UNMATCHED_ID;
      out_q.last             <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Free proposers never outnumber the active size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n_w)
    else $error("free FIFO count exceeds active size");

  // Every preference read was issued from a proposal step
  a_pref_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREF) |-> ($past(state_q) == ST_PROPOSE))
    else $error("preference read without proposal");

  // Rank comparison only against a taken acceptor
  a_hold_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK_HOLD) |-> taken_q[w_q])
    else $error("rank compare on free acceptor");

  // Matched proposers and taken acceptors are equal in number
  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(matched_q) == $countones(taken_q))
    else $error("matched and taken counts differ");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_matching_engine_unit
// Loads preference lists, runs proposer-optimal matchings at many sizes and
// compares every emitted pair against an in-bench Gale-Shapley predictor or a directed expectation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  localparam int CLK_HI         = 6;
  localparam int CLK_LO         = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int ITEM_TARGET    = 170;
  localparam int SMALL_MAX      = 6;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TBL_N          = ID_LIMIT;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Directed table row kinds
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_BEAT,
    ROW_TYPED
  } row_kind_e;

  // Receiver stall styles
  typedef enum logic [1:0] {
    SM_OPEN,
    SM_RANDOM,
    SM_PERIODIC,
    SM_HEAVY
  } stall_mode_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CNT_W-1:0] size;
    sme_in_t         beat;
    logic [ID_W-1:0] acc;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  sme_in_t          in_beat   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sme_out_t         out_beat;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Predictor state: preference lists, inverted acceptor lists, size register
  logic [ID_W-1:0]  prop_choice [TBL_N*TBL_N];
  logic [ID_W-1:0]  acc_rank    [TBL_N*TBL_N];
  logic [CNT_W-1:0] size_now = SIZE_RESET;
  sme_out_t         match_q [$];

  int perm_buf [TBL_N];
  int burst_left  = 0;
  int beats_sent  = 0;
  int fail_cnt    = 0;
  int idle_cycles = 0;

  stall_mode_e stall_mode = SM_OPEN;
  int          stall_left = 0;
  int          stall_tick = 0;

  // Short directed walk: size 1 cases, size 0, ignored code, equal ranks, size 63
  dir_row_t dir_tbl [21] = '{
    '{ROW_CFG,   6'd1,  '0,                                    5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_TYPED, 6'd0,  '{FUNC_START,     5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd0,  5'd0,  5'd31}, 5'd0},
    '{ROW_TYPED, 6'd0,  '{FUNC_START,     5'd31, 5'd31, 5'd31}, UNMATCHED_ID},
    '{ROW_CFG,   6'd0,  '0,                                    5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_TYPED, 6'd0,  '{FUNC_START,     5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_UNUSED,    5'd31, 5'd31, 5'd31}, 5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd31, 5'd31, 5'd31}, 5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_ACC,  5'd31, 5'd31, 5'd31}, 5'd0},
    '{ROW_CFG,   6'd2,  '0,                                    5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd0,  5'd1,  5'd1},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd1,  5'd0,  5'd0},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_PROP, 5'd1,  5'd1,  5'd1},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_ACC,  5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_LOAD_ACC,  5'd0,  5'd0,  5'd1},  5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_START,     5'd0,  5'd0,  5'd0},  5'd0},
    '{ROW_CFG,   6'd63, '0,                                    5'd0},
    '{ROW_BEAT,  6'd0,  '{FUNC_START,     5'd0,  5'd0,  5'd0},  5'd0}
  };

  stable_matching_engine_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Clock
  always begin
    clk = 1'b1;
    #CLK_HI;
    clk = 1'b0;
    #CLK_LO;
  end

  // Gale-Shapley with a FIFO of free proposers; queues one pair per proposer
  task automatic predict_match();
    int         n, m, w, h, head, cnt;
    int         fifo_ids [TBL_N];
    int         next_rank [TBL_N];
    bit         acc_taken [TBL_N];
    int         holder [TBL_N];
    int         paired [TBL_N];
    bit         matched [TBL_N];
    sme_out_t   pr;
    n = size_now;
    if (n == 0) n = 1;
    if (n > TBL_N) n = TBL_N;
    for (int k = 0; k < TBL_N; k++) begin
      fifo_ids[k]  = k;
      next_rank[k] = 0;
      acc_taken[k] = 1'b0;
      holder[k]    = 0;
      paired[k]    = 0;
      matched[k]   = 1'b0;
    end
    head = 0;
    cnt  = n;
    while (cnt > 0) begin
      m = fifo_ids[head];
      // list ran out: proposer leaves unmatched
      if (next_rank[m] >= n) begin
        head = (head + 1) % TBL_N;
        cnt--;
        continue;
      end
      w = prop_choice[m*TBL_N + next_rank[m]];
      next_rank[m]++;
      // acceptor outside the active set counts as a rejection
      if (w >= n) continue;
      if (!acc_taken[w]) begin
        acc_taken[w] = 1'b1;
        holder[w]    = m;
        paired[m]    = w;
        matched[m]   = 1'b1;
        head = (head + 1) % TBL_N;
        cnt--;
      end else begin
        h = holder[w];
        // ties go to the newcomer
        if (acc_rank[w*TBL_N + m] <= acc_rank[w*TBL_N + h]) begin
          holder[w]  = m;
          paired[m]  = w;
          matched[m] = 1'b1;
          matched[h] = 1'b0;
          head = (head + 1) % TBL_N;
          cnt--;
          fifo_ids[(head + cnt) % TBL_N] = h;
          cnt++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      pr.proposer_id      = 5'(i);
      pr.matched_acceptor = matched[i] ? 5'(paired[i]) : UNMATCHED_ID;
      pr.last             = (i + 1 == n);
      match_q.push_back(pr);
    end
  endtask

  function automatic sme_in_t beat_of(input logic [FUNC_W-1:0] func, input int person,
                                      input int rank, input int partner);
    sme_in_t b;
    b.func    = func;
    b.person  = 5'(person);
    b.rank    = 5'(rank);
    b.partner = 5'(partner);
    return b;
  endfunction

  // Drive one input beat in bursts with random gaps, then update the predictor
  task automatic send_beat(input sme_in_t beat, input bit typed = 1'b0,
                           input logic [ID_W-1:0] typed_acc = '0);
    int       gap;
    bit       took;
    sme_out_t pr;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    burst_left--;
    beats_sent++;
    case (beat.func)
      FUNC_LOAD_PROP: prop_choice[{beat.person, beat.rank}] = beat.partner;
      FUNC_LOAD_ACC:  acc_rank[{beat.person, beat.partner}] = beat.rank;
      FUNC_START: begin
        if (typed) begin
          pr.proposer_id      = '0;
          pr.matched_acceptor = typed_acc;
          pr.last             = 1'b1;
          match_q.push_back(pr);
        end else begin
          predict_match();
        end
      end
      default: ;
    endcase
  endtask

  task automatic shuffle_perm(input int n);
    int j, t;
    for (int k = 0; k < n; k++) perm_buf[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = perm_buf[k];
      perm_buf[k] = perm_buf[j];
      perm_buf[j] = t;
    end
  endtask

  task automatic load_prop_list(input int p, input int n);
    shuffle_perm(n);
    for (int r = 0; r < n; r++) send_beat(beat_of(FUNC_LOAD_PROP, p, r, perm_buf[r]));
  endtask

  // exact = 0 gives random ranks, so ties show up
  task automatic load_acc_list(input int a, input int n, input bit exact);
    shuffle_perm(n);
    for (int r = 0; r < n; r++) begin
      send_beat(beat_of(FUNC_LOAD_ACC, a, exact ? r : $urandom_range(0, n - 1), perm_buf[r]));
    end
  endtask

  // Distinct first choices: every proposer is taken on its first proposal
  task automatic load_first_choices(input int n);
    shuffle_perm(n);
    for (int p = 0; p < n; p++) send_beat(beat_of(FUNC_LOAD_PROP, p, 0, perm_buf[p]));
  endtask

  // Drain all pending pairs, then let the engine settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_now = v;
  endtask

  task automatic check_pair(input sme_out_t got);
    sme_out_t want;
    if (match_q.size() == 0) begin
      $error("unexpected pair: proposer_id %0d matched_acceptor %0d last %0b",
             got.proposer_id, got.matched_acceptor, got.last);
      fail_cnt++;
    end else begin
      want = match_q.pop_front();
      if (got.proposer_id !== want.proposer_id) begin
        $error("proposer_id: expected %0d, got %0d", want.proposer_id, got.proposer_id);
        fail_cnt++;
      end
      if (got.matched_acceptor !== want.matched_acceptor) begin
        $error("matched_acceptor: expected %0d, got %0d",
               want.matched_acceptor, got.matched_acceptor);
        fail_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        fail_cnt++;
      end
    end
  endtask

  // Receiver stall pattern, switching at random among four styles
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(64, 256);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      SM_OPEN:     out_stall <= 1'b0;
      SM_RANDOM:   out_stall <= ($urandom_range(0, 9) < 3);
      SM_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default:     out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Output beats are taken at the next rising edge; values are stable here
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_pair(out_beat);
  end

  // Watchdog on cycles with no beat moving on either side
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int  n, cfg_val, pick, left;
    bit  exact;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // each proposer's first choice is itself; the full-size directed run relies on it
    for (int p = 0; p < TBL_N; p++) send_beat(beat_of(FUNC_LOAD_PROP, p, 0, p));
    send_beat(beat_of(FUNC_START, 0, 0, 0));

    // directed table
    foreach (dir_tbl[i]) begin
      case (dir_tbl[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_size(dir_tbl[i].size);
        end
        ROW_TYPED: send_beat(dir_tbl[i].beat, 1'b1, dir_tbl[i].acc);
        default:   send_beat(dir_tbl[i].beat);
      endcase
    end

    // random phases: full lists at small sizes, distinct first choices at large ones
    while (beats_sent < ITEM_TARGET) begin
      left = ITEM_TARGET - beats_sent;
      pick = $urandom_range(0, 19);
      if (pick < 14) n = $urandom_range(1, 4);
      else if (pick < 17) n = $urandom_range(5, SMALL_MAX);
      else n = $urandom_range(SMALL_MAX + 1, TBL_N);
      // keep the total near the item budget
      if (n > SMALL_MAX && n + 2 > left) n = 1;
      if (n <= SMALL_MAX) begin
        while (n > 1 && 2 * n * n + 2 > left) n--;
      end
      cfg_val = n;
      if (n == 1 && $urandom_range(0, 1)) cfg_val = 0;
      if (n == TBL_N && $urandom_range(0, 1)) cfg_val = $urandom_range(33, 63);
      wait_idle();
      write_size(6'(cfg_val));
      if (n <= SMALL_MAX) begin
        exact = ($urandom_range(0, 3) != 0);
        for (int p = 0; p < n; p++) load_prop_list(p, n);
        for (int a = 0; a < n; a++) load_acc_list(a, n, exact);
        // stray loads over a fully loaded block
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) begin
              send_beat(beat_of(FUNC_UNUSED, $urandom, $urandom, $urandom));
            end else begin
              send_beat(beat_of($urandom_range(0, 1) ? FUNC_LOAD_ACC : FUNC_LOAD_PROP,
                                $urandom, $urandom, $urandom));
            end
          end
        end
      end else begin
        load_first_choices(n);
      end
      if ($urandom_range(0, 3) == 0) send_beat(beat_of(FUNC_UNUSED, $urandom, $urandom, $urandom));
      send_beat(beat_of(FUNC_START, $urandom, $urandom, $urandom));
    end

    wait_idle();
    if (match_q.size() != 0) begin
      $error("%0d expected pairs never arrived", match_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
